// ===== sv/lpl_pkg.sv =====
// shared types, widths and constants of the lookahead peak limiter
package lpl_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned GainedW = 28;
  localparam int unsigned CeilW   = 17;
  localparam int unsigned QuotW   = 24;
  localparam int unsigned MulAW   = 28;
  localparam int unsigned MulBW   = 26;
  localparam int unsigned ProdW   = MulAW + MulBW;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 24;

  localparam logic [CfgIdxW-1:0] CFG_INPUT_GAIN    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CEILING_LEVEL = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_COEFF = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LOOKAHEAD_LEN = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_STEREO_ON     = 3'd4;

  localparam logic [19:0] RST_INPUT_GAIN    = 20'd65536;
  localparam logic [16:0] RST_CEILING_LEVEL = 17'd63347;
  localparam logic [23:0] RST_RELEASE_COEFF = 24'd3495;
  localparam logic [8:0]  RST_LOOKAHEAD_LEN = 9'd240;
  localparam logic        RST_STEREO_ON     = 1'b1;

  localparam logic [24:0] GAIN_ONE = 25'h100_0000;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } lpl_in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
    logic [CeilW-1:0]          gain_now;
  } lpl_out_t;

  typedef struct packed {
    logic                start;
    logic [SampleW-1:0]  rem_init;
    logic [GainedW-1:0]  divisor;
  } lpl_div_req_t;

endpackage

// ===== sv/lpl_ram.sv =====
// generic single write port ram with registered read
module lpl_ram #(
  parameter int unsigned WIDTH = 28,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== sv/lpl_mul.sv =====
// shared signed multiplier with registered product
module lpl_mul (
  input  logic                              clk_i,
  input  logic signed [lpl_pkg::MulAW-1:0]  a_i,
  input  logic signed [lpl_pkg::MulBW-1:0]  b_i,
  output logic signed [lpl_pkg::ProdW-1:0]  p_o
);

  always_ff @(posedge clk_i) begin
    p_o <= lpl_pkg::ProdW'(a_i) * lpl_pkg::ProdW'(b_i);
  end

endmodule

// ===== sv/lpl_div.sv =====
// restoring divider, one quotient bit per cycle, for the target gain
module lpl_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpl_pkg::lpl_div_req_t         req_i,
  output logic                          done_o,
  output logic [lpl_pkg::QuotW-1:0]     quot_o
);

  logic [lpl_pkg::GainedW-1:0] rem_q;
  logic [lpl_pkg::GainedW-1:0] div_q;
  logic [lpl_pkg::QuotW-1:0]   quot_q;
  logic [4:0]                  cnt_q;
  logic                        done_q;
  logic [lpl_pkg::GainedW:0]   trial;
  logic [lpl_pkg::GainedW:0]   diff;
  logic                        fits;

  assign trial = {rem_q, 1'b0};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = trial >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == 5'd1);
      if (req_i.start) begin
        cnt_q <= 5'(lpl_pkg::QuotW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= lpl_pkg::GainedW'(req_i.rem_init);
      div_q  <= req_i.divisor;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= fits ? diff[lpl_pkg::GainedW-1:0] : trial[lpl_pkg::GainedW-1:0];
      quot_q <= {quot_q[lpl_pkg::QuotW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== sv/lookahead_peak_limiter_unit.sv =====
// stereo lookahead peak limiter: sequencer around a shared multiplier and divider
// per pair the states run GL, GR, PK, PEAK, TGT, DIV (24-step divider, only over ceiling), REL,
// RELW (only on release), OL, OR, FIN, OUT, with 5 multiplies; a new pair waits for idle
// reset: control, gain and registers go to their defaults, then a pass over every address
// of the delay line zeroes it while no input is taken
// configuration writes are taken at any time
module lookahead_peak_limiter_unit #(
  parameter int unsigned MAX_LOOKAHEAD = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpl_pkg::lpl_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output lpl_pkg::lpl_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lpl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lpl_pkg::CfgDatW-1:0]   cfg_data_i
);

  localparam int unsigned PW = (MAX_LOOKAHEAD > 1) ? $clog2(MAX_LOOKAHEAD) : 1;
  localparam int unsigned LW = ($clog2(MAX_LOOKAHEAD) + 1 > 9) ? $clog2(MAX_LOOKAHEAD) + 1 : 9;
  localparam int unsigned GW = lpl_pkg::GainedW;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_GL    = 4'd2;
  localparam logic [3:0] S_GR    = 4'd3;
  localparam logic [3:0] S_PK    = 4'd4;
  localparam logic [3:0] S_PEAK  = 4'd5;
  localparam logic [3:0] S_TGT   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_REL   = 4'd8;
  localparam logic [3:0] S_RELW  = 4'd9;
  localparam logic [3:0] S_OL    = 4'd10;
  localparam logic [3:0] S_OR    = 4'd11;
  localparam logic [3:0] S_FIN   = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  function automatic logic signed [GW-1:0] sat_gained(
    input logic signed [lpl_pkg::ProdW-1:0] p
  );
    logic signed [lpl_pkg::ProdW-1:0] r;
    r = (p + lpl_pkg::ProdW'(32768)) >>> 16;
    if (r > lpl_pkg::ProdW'(134217727)) begin
      r = lpl_pkg::ProdW'(134217727);
    end else if (r < -lpl_pkg::ProdW'(134217728)) begin
      r = -lpl_pkg::ProdW'(134217728);
    end
    return r[GW-1:0];
  endfunction

  function automatic logic signed [lpl_pkg::SampleW-1:0] sat_out(
    input logic signed [lpl_pkg::ProdW-1:0] p
  );
    logic signed [lpl_pkg::ProdW-1:0] r;
    r = (p + lpl_pkg::ProdW'(8388608)) >>> 24;
    if (r > lpl_pkg::ProdW'(8388607)) begin
      r = lpl_pkg::ProdW'(8388607);
    end else if (r < -lpl_pkg::ProdW'(8388608)) begin
      r = -lpl_pkg::ProdW'(8388608);
    end
    return r[lpl_pkg::SampleW-1:0];
  endfunction

  logic [3:0]  state_q, state_d;
  logic [PW-1:0] clr_q;
  logic [PW-1:0] pos_q;
  logic [24:0] g_q;

  logic [19:0] ig_q;
  logic [16:0] ceil_q;
  logic [23:0] rc_q;
  logic [8:0]  len_q;
  logic        st_q;

  logic signed [lpl_pkg::SampleW-1:0] in_l_q, in_r_q;
  logic signed [GW-1:0] gl_q, gr_q, dl_q, dr_q;
  logic [GW-1:0]        peak_q;
  logic [24:0]          tgt_q;
  logic signed [lpl_pkg::SampleW-1:0] res_l_q, res_r_q;
  lpl_pkg::lpl_out_t    out_q;
  logic                 out_valid_q;

  logic signed [lpl_pkg::MulAW-1:0] mul_a;
  logic signed [lpl_pkg::MulBW-1:0] mul_b;
  logic signed [lpl_pkg::ProdW-1:0] prod;

  lpl_pkg::lpl_div_req_t    div_req;
  logic                     div_done;
  logic [lpl_pkg::QuotW-1:0] div_quot;

  logic          clearing;
  logic          ram_we_l, ram_we_r;
  logic [PW-1:0] ram_waddr;
  logic [GW-1:0] ram_wdata_l, ram_wdata_r;
  logic [GW-1:0] ram_rdata_l, ram_rdata_r;

  logic [GW-1:0] abs_l, abs_r;
  logic [23:0]   ceil23;
  logic          over;
  logic [24:0]   g_diff;
  logic [lpl_pkg::ProdW-1:0] rel_sum;
  logic [LW-1:0] len_eff, pos_inc;
  logic          out_free;

  assign clearing   = state_q == S_CLEAR;
  assign in_ready_o = state_q == S_IDLE;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  assign abs_l   = gl_q[GW-1] ? GW'(-gl_q) : GW'(gl_q);
  assign abs_r   = gr_q[GW-1] ? GW'(-gr_q) : GW'(gr_q);
  assign ceil23  = {ceil_q, 7'd0};
  assign over    = peak_q > {4'd0, ceil23};
  assign g_diff  = tgt_q - g_q;
  assign rel_sum = (prod + lpl_pkg::ProdW'(24'hFF_FFFF)) >> 24;

  always_comb begin
    if (len_q == '0) begin
      len_eff = LW'(1);
    end else if (LW'(len_q) > LW'(MAX_LOOKAHEAD)) begin
      len_eff = LW'(MAX_LOOKAHEAD);
    end else begin
      len_eff = LW'(len_q);
    end
    pos_inc = LW'(pos_q) + LW'(1);
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_GL: begin
        mul_a = lpl_pkg::MulAW'(in_l_q);
        mul_b = {6'd0, ig_q};
      end
      S_GR: begin
        mul_a = lpl_pkg::MulAW'(in_r_q);
        mul_b = {6'd0, ig_q};
      end
      S_REL: begin
        mul_a = {3'd0, g_diff};
        mul_b = {2'd0, rc_q};
      end
      S_OL: begin
        mul_a = dl_q;
        mul_b = {1'b0, g_q};
      end
      S_OR: begin
        mul_a = dr_q;
        mul_b = {1'b0, g_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_req.start    = (state_q == S_TGT) && over;
  assign div_req.rem_init = ceil23;
  assign div_req.divisor  = peak_q;

  assign ram_waddr   = clearing ? clr_q : pos_q;
  assign ram_we_l    = clearing || (state_q == S_TGT);
  assign ram_we_r    = clearing || ((state_q == S_TGT) && st_q);
  assign ram_wdata_l = clearing ? '0 : gl_q;
  assign ram_wdata_r = clearing ? '0 : gr_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == PW'(MAX_LOOKAHEAD - 1)) state_d = S_IDLE;
      S_IDLE:  if (in_valid_i) state_d = S_GL;
      S_GL:    state_d = S_GR;
      S_GR:    state_d = S_PK;
      S_PK:    state_d = S_PEAK;
      S_PEAK:  state_d = S_TGT;
      S_TGT:   state_d = over ? S_DIV : S_REL;
      S_DIV:   if (div_done) state_d = S_REL;
      S_REL:   state_d = (tgt_q < g_q) ? S_OL : S_RELW;
      S_RELW:  state_d = S_OL;
      S_OL:    state_d = S_OR;
      S_OR:    state_d = S_FIN;
      S_FIN:   state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pos_q       <= '0;
      g_q         <= lpl_pkg::GAIN_ONE;
      out_valid_q <= 1'b0;
      ig_q        <= lpl_pkg::RST_INPUT_GAIN;
      ceil_q      <= lpl_pkg::RST_CEILING_LEVEL;
      rc_q        <= lpl_pkg::RST_RELEASE_COEFF;
      len_q       <= lpl_pkg::RST_LOOKAHEAD_LEN;
      st_q        <= lpl_pkg::RST_STEREO_ON;
    end else begin
      state_q <= state_d;
      if (clearing) begin
        clr_q <= clr_q + PW'(1);
      end
      if (state_q == S_TGT) begin
        pos_q <= (pos_inc >= len_eff) ? '0 : pos_inc[PW-1:0];
      end
      if ((state_q == S_REL) && (tgt_q < g_q)) begin
        g_q <= tgt_q;
      end else if (state_q == S_RELW) begin
        g_q <= g_q + rel_sum[24:0];
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          lpl_pkg::CFG_INPUT_GAIN:    ig_q   <= cfg_data_i[19:0];
          lpl_pkg::CFG_CEILING_LEVEL: ceil_q <= cfg_data_i[16:0];
          lpl_pkg::CFG_RELEASE_COEFF: rc_q   <= cfg_data_i[23:0];
          lpl_pkg::CFG_LOOKAHEAD_LEN: len_q  <= cfg_data_i[8:0];
          lpl_pkg::CFG_STEREO_ON:     st_q   <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        in_l_q <= in_data_i.left_in;
        in_r_q <= in_data_i.right_in;
      end
      S_GR: begin
        gl_q <= sat_gained(prod);
        dl_q <= ram_rdata_l;
        dr_q <= ram_rdata_r;
      end
      S_PK:   gr_q <= st_q ? sat_gained(prod) : '0;
      S_PEAK: peak_q <= (abs_l > abs_r) ? abs_l : abs_r;
      S_TGT:  tgt_q <= lpl_pkg::GAIN_ONE;
      S_DIV:  if (div_done) tgt_q <= {1'b0, div_quot};
      S_OR:   res_l_q <= sat_out(prod);
      S_FIN:  res_r_q <= st_q ? sat_out(prod) : '0;
      S_OUT: begin
        if (out_free) begin
          out_q.left_out  <= res_l_q;
          out_q.right_out <= res_r_q;
          out_q.gain_now  <= g_q[24:8];
        end
      end
      default: ;
    endcase
  end

  lpl_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  lpl_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  lpl_ram #(
    .WIDTH (GW),
    .DEPTH (MAX_LOOKAHEAD)
  ) u_delay_l (
    .clk_i   (clk_i),
    .we_i    (ram_we_l),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata_l),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata_l)
  );

  lpl_ram #(
    .WIDTH (GW),
    .DEPTH (MAX_LOOKAHEAD)
  ) u_delay_r (
    .clk_i   (clk_i),
    .we_i    (ram_we_r),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata_r),
    .raddr_i (pos_q),
    .rdata_o (ram_rdata_r)
  );

endmodule
